// ----- rtl/core/rgb3_pkg.sv -----
`timescale 1ns / 1ps

package rgb3_pkg;

	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_ONLY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_LOW   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_HIGH  = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [7:0] EVEN_FIELD = 8'b0001_1100;
	localparam logic [7:0] ODD_FIELD  = 8'b1110_0000;

	localparam int unsigned RED_MSB   = 15;
	localparam int unsigned GREEN_MSB = 10;
	localparam int unsigned BLUE_MSB  = 4;

	localparam int unsigned KEEP_PER_REG = 4;

	typedef enum logic [1:0] {
		ST_WRITTEN   = 2'd0,
		ST_SKIPPED   = 2'd1,
		ST_DROPPED   = 2'd2,
		ST_READ_DONE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_READ  = 4'b0100,
		S_WB    = 4'b1000
	} state_t;

	typedef struct packed {
		logic                  landscape;
		logic                  keep_only;
		logic [CFG_DATA_W-1:0] keep_low;
		logic [CFG_DATA_W-1:0] keep_high;
	} cfg_t;

	typedef struct packed {
		status_t    status;
		logic       mem_rd;
		logic       mem_wr;
		logic       odd;
		logic [2:0] bits;
	} map_t;

endpackage

// ----- rtl/core/rgb3_req_if.sv -----
`timescale 1ns / 1ps

interface rgb3_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [8:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic [15:0] pixel_color;
	logic [7:0]  byte_row;
	logic [8:0]  byte_col;

	modport source (
		output valid, operation, pixel_x, pixel_y, pixel_color, byte_row, byte_col,
		input  ready
	);
	modport sink (
		input  valid, operation, pixel_x, pixel_y, pixel_color, byte_row, byte_col,
		output ready
	);
endinterface

// ----- rtl/core/rgb3_rsp_if.sv -----
`timescale 1ns / 1ps

interface rgb3_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] read_data;

	modport source (
		output valid, status, read_data,
		input  ready
	);
	modport sink (
		input  valid, status, read_data,
		output ready
	);
endinterface

// ----- rtl/core/rgb3_ram.sv -----
`timescale 1ns / 1ps

module rgb3_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 60400
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/rgb3_map.sv -----
`timescale 1ns / 1ps

module rgb3_map #(
	parameter int unsigned PANEL_WIDTH  = 300,
	parameter int unsigned PANEL_HEIGHT = 400,
	parameter int unsigned ROW_BYTES    = 302,
	parameter int unsigned AW           = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  rgb3_pkg::cfg_t       cfg,
	input  logic                 operation,
	input  logic [8:0]           pixel_x,
	input  logic [8:0]           pixel_y,
	input  logic [15:0]          pixel_color,
	input  logic [7:0]           byte_row,
	input  logic [8:0]           byte_col,
	output rgb3_pkg::map_t       map_q,
	output logic [AW-1:0]        addr_q
);
	import rgb3_pkg::*;

	localparam int unsigned ROW_PAIRS = (PANEL_HEIGHT + 1) / 2;
	localparam int unsigned MAX_DIM   = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
	localparam int unsigned CW_MIN    = $clog2(MAX_DIM + ROW_BYTES + 2) + 1;
	localparam int unsigned CW        = (CW_MIN > 10) ? CW_MIN : 10;

	logic [CW-1:0] px;
	logic [CW-1:0] py;
	logic [CW-1:0] col;
	logic [8:0]    row;
	logic          in_panel;
	logic          drop;
	logic          kept;
	logic          rd_ok;
	logic [AW:0]   wr_sum;
	logic [AW:0]   rd_sum;
	map_t          map_d;
	logic [AW-1:0] addr_d;

	assign px = CW'(pixel_x);
	assign py = CW'(pixel_y);

	always_comb begin
		if (cfg.landscape) begin
			in_panel = (px < CW'(PANEL_HEIGHT)) && (py < CW'(PANEL_WIDTH));
			col      = in_panel ? (CW'(PANEL_WIDTH - 1) - py) : '0;
			row      = pixel_x;
		end else begin
			in_panel = (px < CW'(PANEL_WIDTH)) && (py < CW'(PANEL_HEIGHT));
			col      = px;
			row      = pixel_y;
		end
		drop = !in_panel || ((col + CW'(2)) >= CW'(ROW_BYTES));
	end

	always_comb begin
		kept = 1'b0;
		for (int i = 0; i < KEEP_PER_REG; i++) begin
			if (cfg.keep_low[16*i +: 16] == pixel_color
					|| cfg.keep_high[16*i +: 16] == pixel_color) begin
				kept = 1'b1;
			end
		end
	end

	assign rd_ok  = (CW'(byte_row) < CW'(ROW_PAIRS)) && (CW'(byte_col) < CW'(ROW_BYTES));
	assign wr_sum = (AW + 1)'(row[8:1]) * (AW + 1)'(ROW_BYTES) + (AW + 1)'(col) + (AW + 1)'(2);
	assign rd_sum = (AW + 1)'(byte_row) * (AW + 1)'(ROW_BYTES) + (AW + 1)'(byte_col);

	always_comb begin
		map_d.odd  = row[0];
		map_d.bits = {pixel_color[BLUE_MSB], pixel_color[GREEN_MSB], pixel_color[RED_MSB]};
		if (operation == OP_READ) begin
			map_d.status = rd_ok ? ST_READ_DONE : ST_DROPPED;
			map_d.mem_rd = rd_ok;
			map_d.mem_wr = 1'b0;
			addr_d       = rd_sum[AW-1:0];
		end else begin
			addr_d = wr_sum[AW-1:0];
			if (drop) begin
				map_d.status = ST_DROPPED;
				map_d.mem_rd = 1'b0;
				map_d.mem_wr = 1'b0;
			end else if (cfg.keep_only && !kept) begin
				map_d.status = ST_SKIPPED;
				map_d.mem_rd = 1'b0;
				map_d.mem_wr = 1'b0;
			end else begin
				map_d.status = ST_WRITTEN;
				map_d.mem_rd = 1'b1;
				map_d.mem_wr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			map_q  <= map_d;
			addr_q <= addr_d;
		end
	end
endmodule

// ----- rtl/core/rgb565_to_packed_3bit_frame_writer.sv -----
`timescale 1ns / 1ps
// channel  dir  payload                                            handshake
// req      in   operation pixel_x pixel_y pixel_color byte_row/col valid/ready
// rsp      out  status read_data                                   valid/ready
// wr_*     in   wr_index wr_data (register write)                  wr_en
//
// Each item passes through three steps: accept and map, frame store read, then
// modify, write back and load the result register.
// After reset a clearing pass zeroes all ((PANEL_HEIGHT+1)/2)*ROW_BYTES bytes of
// the frame store (60400 by default), one byte a cycle; req.ready is low.
// A full result register not taken holds the item in write-back.

module rgb565_to_packed_3bit_frame_writer #(
	parameter int unsigned PANEL_WIDTH  = 300,
	parameter int unsigned PANEL_HEIGHT = 400,
	parameter int unsigned ROW_BYTES    = 302
) (
	input  logic                               clk,
	input  logic                               arst_n,
	rgb3_req_if.sink                           req,
	rgb3_rsp_if.source                         rsp,
	input  logic                               wr_en,
	input  logic [rgb3_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [rgb3_pkg::CFG_DATA_W-1:0]    wr_data
);
	import rgb3_pkg::*;

	localparam int unsigned DEPTH = ((PANEL_HEIGHT + 1) / 2) * ROW_BYTES;
	localparam int unsigned AW    = $clog2(DEPTH);

	state_t        state_q;
	cfg_t          cfg_q;
	logic [AW-1:0] clr_q;
	logic          accept;
	logic          out_free;
	logic          done;
	map_t          map_q;
	logic [AW-1:0] addr_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [7:0]    ram_rdata;
	logic [7:0]    mod_byte;
	logic          out_valid_q;
	status_t       out_status_q;
	logic [7:0]    out_data_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign done      = (state_q == S_WB) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LANDSCAPE: cfg_q.landscape <= wr_data[0];
				REG_KEEP_ONLY: cfg_q.keep_only <= wr_data[0];
				REG_KEEP_LOW:  cfg_q.keep_low  <= wr_data;
				REG_KEEP_HIGH: cfg_q.keep_high <= wr_data;
				default: ;
			endcase
		end
	end

	rgb3_map #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.ROW_BYTES   (ROW_BYTES),
		.AW          (AW)
	) u_map (
		.clk        (clk),
		.en         (accept),
		.cfg        (cfg_q),
		.operation  (req.operation),
		.pixel_x    (req.pixel_x),
		.pixel_y    (req.pixel_y),
		.pixel_color(req.pixel_color),
		.byte_row   (req.byte_row),
		.byte_col   (req.byte_col),
		.map_q      (map_q),
		.addr_q     (addr_q)
	);

	always_comb begin
		if (map_q.odd) begin
			mod_byte = (ram_rdata | ODD_FIELD) & ~{map_q.bits, 5'b0};
		end else begin
			mod_byte = (ram_rdata | EVEN_FIELD) & ~{3'b0, map_q.bits, 2'b0};
		end
	end

	assign ram_re    = (state_q == S_READ) && map_q.mem_rd;
	assign ram_we    = (state_q == S_CLEAR) || (done && map_q.mem_wr);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == S_CLEAR) ? 8'd0 : mod_byte;

	rgb3_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_status_q <= map_q.status;
			out_data_q   <= (map_q.status == ST_READ_DONE) ? ram_rdata : 8'd0;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.read_data = out_data_q;
endmodule

// ----- tb/rgb565_to_packed_3bit_frame_writer_tb.sv -----
`timescale 1ns / 1ps

module rgb565_to_packed_3bit_frame_writer_tb;
	import rgb3_pkg::*;

	localparam int unsigned PANEL_WIDTH  = 300;
	localparam int unsigned PANEL_HEIGHT = 400;
	localparam int unsigned ROW_BYTES    = 302;
	localparam int unsigned ROW_PAIRS    = (PANEL_HEIGHT + 1) / 2;
	localparam int unsigned STORE_BYTES  = ROW_PAIRS * ROW_BYTES;

	typedef struct packed {
		logic        op;
		logic [8:0]  x;
		logic [8:0]  y;
		logic [15:0] color;
		logic [7:0]  brow;
		logic [8:0]  bcol;
	} req_word_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] read_data;
	} rsp_word_t;

	typedef struct packed {
		req_word_t word;
		logic      typed;
		status_t   status;
		logic [7:0] read_data;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] pair;
		logic [8:0] col;
	} byte_addr_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	rgb3_req_if req_ch ();
	rgb3_rsp_if rsp_ch ();

	rgb565_to_packed_3bit_frame_writer #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.ROW_BYTES    (ROW_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #4 clk = ~clk;

	logic [7:0] frame_shadow [0:STORE_BYTES-1];
	logic cfg_landscape;
	logic cfg_keep_only;
	logic [CFG_DATA_W-1:0] cfg_keep_low;
	logic [CFG_DATA_W-1:0] cfg_keep_high;

	rsp_word_t pending_results [$];
	byte_addr_t written_bytes [$];
	rsp_word_t oldest_result;
	int unsigned error_count = 0;
	int unsigned words_sent = 0;
	int unsigned settings_used = 1;
	int unsigned status_seen [4] = '{0, 0, 0, 0};
	logic steady_flow = 1'b0;
	int unsigned rsp_hold = 0;
	int unsigned rsp_gap;

	dir_row_t directed_rows [0:19] = '{
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd0,   9'd0},   1'b1, ST_READ_DONE, 8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd199, 9'd301}, 1'b1, ST_READ_DONE, 8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd200, 9'd0},   1'b1, ST_DROPPED,   8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd0,   9'd302}, 1'b1, ST_DROPPED,   8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd255, 9'd511}, 1'b1, ST_DROPPED,   8'h00},
		'{'{OP_WRITE, 9'd0,   9'd0,   16'h0000, 8'd0,   9'd0},   1'b1, ST_WRITTEN,   8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd0,   9'd2},   1'b1, ST_READ_DONE, 8'h1C},
		'{'{OP_WRITE, 9'd0,   9'd1,   16'hFFFF, 8'd0,   9'd0},   1'b1, ST_WRITTEN,   8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd0,   9'd2},   1'b1, ST_READ_DONE, 8'h1C},
		'{'{OP_WRITE, 9'd299, 9'd399, 16'h8000, 8'd0,   9'd0},   1'b1, ST_WRITTEN,   8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd199, 9'd301}, 1'b1, ST_READ_DONE, 8'hC0},
		'{'{OP_WRITE, 9'd300, 9'd0,   16'h1234, 8'd0,   9'd0},   1'b1, ST_DROPPED,   8'h00},
		'{'{OP_WRITE, 9'd0,   9'd400, 16'h1234, 8'd0,   9'd0},   1'b1, ST_DROPPED,   8'h00},
		'{'{OP_WRITE, 9'd511, 9'd511, 16'hFFFF, 8'd255, 9'd511}, 1'b1, ST_DROPPED,   8'h00},
		'{'{OP_WRITE, 9'd5,   9'd2,   16'h0400, 8'd0,   9'd0},   1'b0, ST_WRITTEN,   8'h00},
		'{'{OP_WRITE, 9'd5,   9'd3,   16'h0010, 8'd0,   9'd0},   1'b0, ST_WRITTEN,   8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd1,   9'd7},   1'b0, ST_READ_DONE, 8'h00},
		'{'{OP_WRITE, 9'd256, 9'd256, 16'h7BEF, 8'd0,   9'd0},   1'b0, ST_WRITTEN,   8'h00},
		'{'{OP_READ,  9'd0,   9'd0,   16'h0000, 8'd128, 9'd258}, 1'b0, ST_READ_DONE, 8'h00},
		'{'{OP_READ,  9'd511, 9'd511, 16'hFFFF, 8'd0,   9'd0},   1'b1, ST_READ_DONE, 8'h00}
	};

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic keep_hit(logic [15:0] color);
		for (int i = 0; i < KEEP_PER_REG; i++) begin
			if (cfg_keep_low[16*i +: 16] == color || cfg_keep_high[16*i +: 16] == color)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic rsp_word_t apply_pixel_op(req_word_t w);
		rsp_word_t r;
		int unsigned col;
		int unsigned row;
		int unsigned idx;
		logic in_panel;
		logic [2:0] bits;
		logic [7:0] v;
		byte_addr_t a;
		r.status = ST_DROPPED;
		r.read_data = 8'h00;
		if (w.op == OP_READ) begin
			if (w.brow < ROW_PAIRS && w.bcol < ROW_BYTES) begin
				r.status = ST_READ_DONE;
				r.read_data = frame_shadow[w.brow * ROW_BYTES + w.bcol];
			end
		end else begin
			if (cfg_landscape) begin
				in_panel = (w.x < PANEL_HEIGHT) && (w.y < PANEL_WIDTH);
				col = in_panel ? PANEL_WIDTH - 1 - w.y : 0;
				row = w.x;
			end else begin
				in_panel = (w.x < PANEL_WIDTH) && (w.y < PANEL_HEIGHT);
				col = w.x;
				row = w.y;
			end
			if (!in_panel || col + 2 >= ROW_BYTES) begin
				r.status = ST_DROPPED;
			end else if (cfg_keep_only && !keep_hit(w.color)) begin
				r.status = ST_SKIPPED;
			end else begin
				idx = (row / 2) * ROW_BYTES + col + 2;
				bits = {w.color[BLUE_MSB], w.color[GREEN_MSB], w.color[RED_MSB]};
				v = frame_shadow[idx];
				if (row % 2 == 0)
					v = (v | EVEN_FIELD) & ~{3'b000, bits, 2'b00};
				else
					v = (v | ODD_FIELD) & ~{bits, 5'b00000};
				frame_shadow[idx] = v;
				r.status = ST_WRITTEN;
				a.pair = 8'(row / 2);
				a.col = 9'(col + 2);
				written_bytes.push_back(a);
				if (written_bytes.size() > 64)
					void'(written_bytes.pop_front());
			end
		end
		return r;
	endfunction

	function automatic logic [8:0] edge_coord(int unsigned lim);
		case ($urandom_range(0, 3))
			0: return 9'd0;
			1: return 9'(lim - 1);
			2: return 9'(lim);
			default: return 9'd511;
		endcase
	endfunction

	function automatic req_word_t random_word();
		req_word_t w;
		int unsigned xlim;
		int unsigned ylim;
		int unsigned r;
		int unsigned k;
		byte_addr_t a;
		w.x = 9'($urandom);
		w.y = 9'($urandom);
		w.color = 16'($urandom);
		w.brow = 8'($urandom);
		w.bcol = 9'($urandom);
		xlim = cfg_landscape ? PANEL_HEIGHT : PANEL_WIDTH;
		ylim = cfg_landscape ? PANEL_WIDTH : PANEL_HEIGHT;
		if ($urandom_range(0, 99) < 30) begin
			w.op = OP_READ;
			if (written_bytes.size() != 0 && $urandom_range(0, 99) < 70) begin
				a = written_bytes[$urandom_range(0, written_bytes.size() - 1)];
				w.brow = a.pair;
				w.bcol = a.col;
			end
		end else begin
			w.op = OP_WRITE;
			r = $urandom_range(0, 99);
			if (r < 80) begin
				w.x = 9'($urandom_range(0, xlim - 1));
				w.y = 9'($urandom_range(0, ylim - 1));
			end else if (r < 90) begin
				w.x = edge_coord(xlim);
				w.y = edge_coord(ylim);
			end
			r = $urandom_range(0, 99);
			if (cfg_keep_only && r < 50) begin
				k = $urandom_range(0, 7);
				w.color = (k < KEEP_PER_REG) ? cfg_keep_low[16*k +: 16]
					: cfg_keep_high[16*(k-KEEP_PER_REG) +: 16];
			end else if (r < 60) begin
				case ($urandom_range(0, 4))
					0: w.color = 16'h0000;
					1: w.color = 16'hFFFF;
					2: w.color = 16'h8000;
					3: w.color = 16'h0400;
					default: w.color = 16'h0010;
				endcase
			end
		end
		return w;
	endfunction

	task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
		error_count++;
	endtask

	task automatic offer_word(req_word_t w, logic typed, rsp_word_t typed_rsp);
		rsp_word_t predicted;
		int unsigned gap;
		req_ch.valid <= 1'b1;
		req_ch.operation <= w.op;
		req_ch.pixel_x <= w.x;
		req_ch.pixel_y <= w.y;
		req_ch.pixel_color <= w.color;
		req_ch.byte_row <= w.brow;
		req_ch.byte_col <= w.bcol;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = apply_pixel_op(w);
		pending_results.push_back(typed ? typed_rsp : predicted);
		words_sent++;
		gap = steady_flow ? 0 : pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_LANDSCAPE: cfg_landscape = data[0];
			REG_KEEP_ONLY: cfg_keep_only = data[0];
			REG_KEEP_LOW:  cfg_keep_low = data;
			REG_KEEP_HIGH: cfg_keep_high = data;
			default: ;
		endcase
	endtask

	task automatic run_setting(logic [63:0] land, logic [63:0] keep, logic [63:0] lo,
			logic [63:0] hi, logic steady, int unsigned count);
		rsp_word_t unused;
		unused = '{ST_WRITTEN, 8'h00};
		set_reg(REG_LANDSCAPE, land);
		set_reg(REG_KEEP_ONLY, keep);
		set_reg(REG_KEEP_LOW, lo);
		set_reg(REG_KEEP_HIGH, hi);
		wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
		steady_flow = steady;
		repeat (count) offer_word(random_word(), 1'b0, unused);
		drain();
	endtask

	always @(posedge clk) begin
		if (rsp_hold != 0) begin
			rsp_hold <= rsp_hold - 1;
		end else if (steady_flow || !rsp_ch.ready) begin
			rsp_ch.ready <= 1'b1;
			rsp_hold <= steady_flow ? 0 : $urandom_range(0, 7);
		end else begin
			rsp_gap = pick_gap();
			rsp_ch.ready <= (rsp_gap == 0);
			rsp_hold <= rsp_gap;
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			status_seen[rsp_ch.status]++;
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing outstanding", {6'd0, rsp_ch.status}, 8'h00);
			end else begin
				oldest_result = pending_results.pop_front();
				if (rsp_ch.status !== oldest_result.status)
					note_mismatch("status", {6'd0, rsp_ch.status}, {6'd0, oldest_result.status});
				if (rsp_ch.read_data !== oldest_result.read_data)
					note_mismatch("read_data", rsp_ch.read_data, oldest_result.read_data);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_LANDSCAPE;
		wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_WRITE;
		req_ch.pixel_x = '0;
		req_ch.pixel_y = '0;
		req_ch.pixel_color = '0;
		req_ch.byte_row = '0;
		req_ch.byte_col = '0;
		rsp_ch.ready = 1'b0;
		cfg_landscape = 1'b0;
		cfg_keep_only = 1'b0;
		cfg_keep_low = '0;
		cfg_keep_high = '0;
		foreach (frame_shadow[i])
			frame_shadow[i] = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_word(directed_rows[i].word, directed_rows[i].typed,
				'{directed_rows[i].status, directed_rows[i].read_data});
		drain();

		run_setting(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, {$urandom, $urandom},
			{$urandom, $urandom}, 1'b0, 300);
		run_setting(64'd0, 64'd1, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 300);
		run_setting(64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, 250);
		run_setting(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, {$urandom, $urandom},
			{$urandom, $urandom}, 1'b0, 350);
		repeat (10) @(posedge clk);

		$display("run: %0d requests over %0d register settings, portrait and landscape",
			words_sent, settings_used);
		$display("results: %0d written, %0d skipped, %0d dropped, %0d reads",
			status_seen[ST_WRITTEN], status_seen[ST_SKIPPED], status_seen[ST_DROPPED],
			status_seen[ST_READ_DONE]);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
